[sv/anchored_regex_line_matcher_macros.svh]
// Assertion macros used by the matcher's top-level file.
`ifndef ANCHORED_REGEX_LINE_MATCHER_MACROS_SVH
`define ANCHORED_REGEX_LINE_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ARLM_ASSERT_IMPLIES(label, antecedent, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |-> (consequent)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ARLM_ASSERT_NEXT(label, antecedent, consequent, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (antecedent) |=> (consequent)) else $error(msg);

`endif

[sv/arlm_pkg.sv]
package arlm_pkg;

    // Pattern special characters.
    localparam logic [7:0] CH_ANY  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_EOL  = 8'h24;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Pattern storage and sizing.
    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int NUM_PATTERN_WORDS   = 4;
    localparam int BYTE_W              = 8;
    localparam int PATTERN_LENGTH_W    = 5;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    // Result word layout.
    localparam int COUNT_W    = 16;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_PAD_W  = OUT_DATA_W - 1 - COUNT_W;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

endpackage

[sv/arlm_front.sv]
module arlm_front
    import arlm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration writes.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Line input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] line_byte
    input  logic                   s_axis_tlast,   // end_of_line
    // Classified words toward the queue: {end_of_line, per-position byte hits}.
    output logic                   push_valid,
    input  logic                   push_ready,
    output logic [PATTERN_MAX:0]   push_data,
    // Decoded pattern, shared with the back part.
    output logic [PATTERN_MAX:0]   pos_mask,
    output logic [PATTERN_MAX:0]   end_oh,
    output logic [PATTERN_MAX-1:0] star_at,
    output logic [PATTERN_MAX-1:0] anchor_at
);

    logic [CFG_DATA_W-1:0]       pattern_word_reg [NUM_PATTERN_WORDS];
    logic [PATTERN_LENGTH_W-1:0] pattern_length_reg;

    logic [BYTE_W-1:0]           pat_byte [PATTERN_MAX+1];
    logic [PATTERN_MAX:0]        in_use;
    logic [PATTERN_MAX-1:0]      byte_hit;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_PATTERN_WORDS; w++)
            begin
                pattern_word_reg[w] <= '0;
            end
            pattern_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_PATTERN_WORD_0: pattern_word_reg[0] <= cfg_wr_data;
                REG_PATTERN_WORD_1: pattern_word_reg[1] <= cfg_wr_data;
                REG_PATTERN_WORD_2: pattern_word_reg[2] <= cfg_wr_data;
                REG_PATTERN_WORD_3: pattern_word_reg[3] <= cfg_wr_data;
                REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_wr_data[PATTERN_LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Pattern decode: a position is in use while it lies below the length and
    // no zero byte has been seen up to and including it.
    always_comb
    begin
        logic nz;
        nz = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat_byte[i] = pattern_word_reg[2'(i >> 2)][BYTE_W*(i & 3) +: BYTE_W];
        end
        pat_byte[PATTERN_MAX] = CH_NUL;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            nz = nz & (pat_byte[i] != CH_NUL)
                    & (pattern_length_reg > PATTERN_LENGTH_W'(i));
            in_use[i] = nz;
        end
        in_use[PATTERN_MAX] = 1'b0;

        pos_mask[0] = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pos_mask[i+1] = in_use[i];
        end
        end_oh = pos_mask & ~in_use;

        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            star_at[i]   = in_use[i+1] & (pat_byte[i+1] == CH_STAR);
            anchor_at[i] = end_oh[i+1] & (pat_byte[i] == CH_EOL);
        end
    end

    // Byte classification: which pattern positions accept the incoming byte.
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            byte_hit[i] = (pat_byte[i] == CH_ANY) || (pat_byte[i] == s_axis_tdata);
        end
    end

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;
    assign push_data     = {s_axis_tlast, byte_hit};

endmodule

[sv/arlm_fifo.sv]
module arlm_fifo
    import arlm_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Storage; words need no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/arlm_back.sv]
module arlm_back
    import arlm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Classified words from the queue: {end_of_line, per-position byte hits}.
    input  logic                   q_valid,
    output logic                   q_pop,
    input  logic [PATTERN_MAX:0]   q_data,
    // Decoded pattern.
    input  logic [PATTERN_MAX:0]   pos_mask,
    input  logic [PATTERN_MAX:0]   end_oh,
    input  logic [PATTERN_MAX-1:0] star_at,
    input  logic [PATTERN_MAX-1:0] anchor_at,
    // Result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [0] line_matched, [16:1] matching_lines
);

    logic [PATTERN_MAX:0] active_reg;
    logic                 prefix_reg;
    logic                 check_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 out_valid_reg;
    logic                 out_matched_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic                   q_eol;
    logic [PATTERN_MAX-1:0] byte_hit;
    logic [PATTERN_MAX:0]   in_use;
    logic [PATTERN_MAX:0]   clo;
    logic [PATTERN_MAX:0]   active_next;
    logic                   end_hit;
    logic                   prefix_now;
    logic                   anchor_hit;
    logic                   line_match;
    logic [COUNT_W-1:0]     count_next;

    assign q_eol    = q_data[PATTERN_MAX];
    assign byte_hit = q_data[PATTERN_MAX-1:0];
    assign in_use   = pos_mask & ~end_oh;

    // Closure: an active star token may also be skipped over.
    always_comb
    begin
        clo = active_reg & pos_mask;
        for (int i = 0; i + 2 <= PATTERN_MAX; i++)
        begin
            clo[i+2] = clo[i+2] | (clo[i] & star_at[i]);
        end
    end

    assign end_hit    = |(clo & end_oh);
    assign prefix_now = prefix_reg | end_hit;
    assign anchor_hit = |(clo[PATTERN_MAX-1:0] & anchor_at);
    assign line_match = prefix_now | anchor_hit;
    assign count_next = (line_match && (count_reg != '1)) ? count_reg + 1'b1 : count_reg;

    // Byte step: a star token loops on itself and hides the star position
    // behind it, a final dollar takes no byte, any other position advances.
    always_comb
    begin
        logic skip;
        logic proc;
        skip        = 1'b0;
        proc        = 1'b0;
        active_next = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            proc = clo[i] & in_use[i] & ~skip;
            if (proc && star_at[i])
            begin
                active_next[i] = active_next[i] | byte_hit[i];
            end
            else if (proc && !anchor_at[i])
            begin
                active_next[i+1] = active_next[i+1] | byte_hit[i];
            end
            skip = proc & star_at[i];
        end
    end

    // An end word waits for the output register; byte words never wait.
    assign q_pop = q_valid && (!q_eol || !out_valid_reg || m_axis_tready);

    // Line state and match counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (PATTERN_MAX+1)'(1);
            prefix_reg <= 1'b0;
            check_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else if (q_pop && q_eol)
        begin
            active_reg <= (PATTERN_MAX+1)'(1);
            prefix_reg <= 1'b0;
            check_reg  <= 1'b0;
            count_reg  <= count_next;
        end
        else if (q_pop)
        begin
            active_reg <= active_next;
            prefix_reg <= prefix_now;
            check_reg  <= 1'b1;
        end
        else if (check_reg)
        begin
            // Settle the end-of-pattern check for the last byte.
            prefix_reg <= prefix_now;
            check_reg  <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && q_eol)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_eol)
        begin
            out_matched_reg <= line_match;
            out_count_reg   <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_count_reg, out_matched_reg};

endmodule

[sv/anchored_regex_line_matcher.sv]
// Channel    | Handshake                    | Words
// -----------+------------------------------+--------------------------------------
// line in    | s_axis_tvalid/s_axis_tready  | tdata[7:0] line byte, tlast end of line
// result out | m_axis_tvalid/m_axis_tready  | tdata[0] matched, tdata[16:1] count
// config     | cfg_wr_en (no wait)          | cfg_wr_index, cfg_wr_data
//
// One word is accepted per cycle while the queue has room; the front classifies
// the byte against all pattern positions in the cycle it is accepted and pushes
// the word into the queue, from whose head the back pops it to update the position
// set or, for an end word, to load the result register.
// Reset clears the pattern, the line state and the count; there is no clear pass.
// A stalled result holds back only end words; behind a held end word the two-word queue takes one more word.
`include "anchored_regex_line_matcher_macros.svh"

module anchored_regex_line_matcher
    import arlm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] line_byte
    input  logic                   s_axis_tlast,   // end_of_line
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata    // [0] line_matched, [16:1] matching_lines
);

    logic                   push_valid;
    logic                   push_ready;
    logic [PATTERN_MAX:0]   push_data;
    logic                   q_valid;
    logic                   q_pop;
    logic [PATTERN_MAX:0]   q_data;
    logic [PATTERN_MAX:0]   pos_mask;
    logic [PATTERN_MAX:0]   end_oh;
    logic [PATTERN_MAX-1:0] star_at;
    logic [PATTERN_MAX-1:0] anchor_at;

    // Front: configuration, pattern decode and byte classification.
    arlm_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data),
        .pos_mask      (pos_mask),
        .end_oh        (end_oh),
        .star_at       (star_at),
        .anchor_at     (anchor_at)
    );

    // Queue between the two parts.
    arlm_fifo #(
        .WIDTH (PATTERN_MAX + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    // Back: position-set update, counter and result register.
    arlm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .pos_mask      (pos_mask),
        .end_oh        (end_oh),
        .star_at       (star_at),
        .anchor_at     (anchor_at),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A full queue always has a word at its head for the back part.
    `ARLM_ASSERT_IMPLIES(a_full_queue_has_head, !s_axis_tready, q_valid, "queue full but empty head")

    // A matching line has been counted, so the count is never zero.
    `ARLM_ASSERT_IMPLIES(a_match_counted, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[COUNT_W:1] != '0, "matched line with zero count")

    // The count of matching lines never goes down from one result to the next.
    `ARLM_ASSERT_NEXT(a_count_monotonic, m_axis_tvalid && m_axis_tready, !m_axis_tvalid || (m_axis_tdata[COUNT_W:1] >= $past(m_axis_tdata[COUNT_W:1])), "match count decreased")

endmodule
